FILE: rtl/assert_macros.svh
// assertion macros for the rsa block
// used by the top level only, needs clk and rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition that must never hold outside reset
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

FILE: rtl/trsa_pkg.sv
// shared types and constants of the textbook rsa block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package trsa_pkg;

  localparam int PRIME_WIDTH = 16;
  localparam int CFG_WIDTH   = 16;
  localparam int WORD_WIDTH  = 32;
  localparam int MUL_WIDTH   = 34;
  localparam int DIV_STEPS   = 64;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS + 1);

  localparam logic [PRIME_WIDTH-1:0] PRIME_P_RESET = PRIME_WIDTH'(61);
  localparam logic [PRIME_WIDTH-1:0] PRIME_Q_RESET = PRIME_WIDTH'(53);

  localparam logic REG_PRIME_P = 1'b0;
  localparam logic REG_PRIME_Q = 1'b1;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_MUL_N,
    OP_MUL_PHI,
    OP_SET_PHI,
    OP_SMALL_KEYS,
    OP_E_INIT,
    OP_GCD_LOAD,
    OP_DIV_EUC,
    OP_DIV_MOD,
    OP_GCD_STEP,
    OP_NEXT_I,
    OP_SET_E,
    OP_INV_LOAD,
    OP_INV_MUL,
    OP_INV_STEP,
    OP_SET_D,
    OP_X1_INIT,
    OP_X2_INIT,
    OP_ZERO_ACC,
    OP_LOAD_ONE,
    OP_LOAD_BASE,
    OP_SET_ACC,
    OP_SET_BASE,
    OP_SET_BASE_SH,
    OP_MUL_AB,
    OP_MUL_BB,
    OP_FINISH
  } op_t;

  typedef struct packed {
    op_t  op;
    logic msg_load;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
    logic phi_small;
    logic rb_zero;
    logic ra_one;
    logic i_ge_phi;
    logic mod_zero;
    logic exp_zero;
    logic exp_lsb;
    logic keys_ready;
  } status_t;

endpackage

`default_nettype wire

FILE: rtl/trsa_datapath.sv
// datapath: key registers, shared multiplier, bit-serial divider, exponent state
// depends on trsa_pkg, driven by trsa_ctrl
`timescale 1ns / 1ps
`default_nettype none

module trsa_datapath import trsa_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic                  cfg_addr,
  input  wire logic [CFG_WIDTH-1:0]  cfg_wdata,
  input  wire logic [7:0]            msg,
  input  wire cmd_t                  cmd,
  output status_t                    st,
  output logic [WORD_WIDTH-1:0]      cipher_out,
  output logic [WORD_WIDTH-1:0]      rec_out,
  output logic [WORD_WIDTH-1:0]      e_out,
  output logic [WORD_WIDTH-1:0]      d_out
);

  logic [PRIME_WIDTH-1:0] p_r, q_r, pm, qm;
  logic [WORD_WIDTH-1:0]  modulus_r, totient_r, e_r, d_r;
  logic                   keys_ready_r;
  logic [WORD_WIDTH-1:0]  ra_r, rb_r, i_r;
  logic signed [MUL_WIDTH-1:0] t_r, nt_r, t_fix;
  logic [WORD_WIDTH-1:0]  acc_r, base_r, exp_r, cipher_r, out_cipher_r, out_rec_r;
  logic [7:0]             msg_r;
  logic [63:0]            prod_r;

  // divider: dq_r shifts the dividend out and the quotient in
  logic [63:0]            dq_r;
  logic [WORD_WIDTH-1:0]  rem_r, divisor_r, rem_nxt;
  logic [DIV_CNT_W-1:0]   cnt_r;
  logic [WORD_WIDTH:0]    rem_sh;
  logic                   q_bit;

  logic signed [MUL_WIDTH-1:0]   mul_a, mul_b;
  logic signed [2*MUL_WIDTH-1:0] mul_p;
  logic                          mul_en;

  assign pm = (p_r != '0) ? p_r - 1'b1 : '0;
  assign qm = (q_r != '0) ? q_r - 1'b1 : '0;

  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_en = 1'b1;
    case (cmd.op)
      OP_MUL_N: begin
        mul_a = $signed(MUL_WIDTH'(p_r));
        mul_b = $signed(MUL_WIDTH'(q_r));
      end
      OP_MUL_PHI: begin
        mul_a = $signed(MUL_WIDTH'(pm));
        mul_b = $signed(MUL_WIDTH'(qm));
      end
      OP_INV_MUL: begin
        mul_a = $signed(MUL_WIDTH'(dq_r[WORD_WIDTH-1:0]));
        mul_b = nt_r;
      end
      OP_MUL_AB: begin
        mul_a = $signed(MUL_WIDTH'(acc_r));
        mul_b = $signed(MUL_WIDTH'(base_r));
      end
      OP_MUL_BB: begin
        mul_a = $signed(MUL_WIDTH'(base_r));
        mul_b = $signed(MUL_WIDTH'(base_r));
      end
      OP_LOAD_ONE: begin
        mul_a = MUL_WIDTH'(1);
        mul_b = MUL_WIDTH'(1);
      end
      OP_LOAD_BASE: begin
        mul_a = $signed(MUL_WIDTH'(base_r));
        mul_b = MUL_WIDTH'(1);
      end
      default: mul_en = 1'b0;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  assign rem_sh  = {rem_r, dq_r[63]};
  assign q_bit   = rem_sh >= {1'b0, divisor_r};
  assign rem_nxt = q_bit ? WORD_WIDTH'(rem_sh - {1'b0, divisor_r}) : rem_sh[WORD_WIDTH-1:0];

  // negative bezout coefficient folds back into [0, phi)
  assign t_fix = t_r[MUL_WIDTH-1] ? t_r + $signed(MUL_WIDTH'(totient_r)) : t_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_r          <= PRIME_P_RESET;
      q_r          <= PRIME_Q_RESET;
      modulus_r    <= '0;
      totient_r    <= '0;
      e_r          <= '0;
      d_r          <= '0;
      keys_ready_r <= 1'b0;
      cnt_r        <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_PRIME_P: p_r <= PRIME_WIDTH'(cfg_wdata);
          REG_PRIME_Q: q_r <= PRIME_WIDTH'(cfg_wdata);
          default: ;
        endcase
      end
      if (cmd.op == OP_DIV_EUC || cmd.op == OP_DIV_MOD) begin
        cnt_r <= DIV_CNT_W'(DIV_STEPS);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - 1'b1;
      end
      case (cmd.op)
        OP_MUL_PHI: modulus_r <= prod_r[WORD_WIDTH-1:0];
        OP_SET_PHI: totient_r <= prod_r[WORD_WIDTH-1:0];
        OP_SMALL_KEYS: begin
          e_r          <= WORD_WIDTH'(2);
          d_r          <= WORD_WIDTH'(2);
          keys_ready_r <= 1'b1;
        end
        OP_SET_E: e_r <= i_r;
        OP_SET_D: begin
          d_r          <= (t_fix[WORD_WIDTH-1:0] >= WORD_WIDTH'(2)) ?
                          t_fix[WORD_WIDTH-1:0] : totient_r;
          keys_ready_r <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mul_en) prod_r <= mul_p[63:0];
    if (cmd.msg_load) msg_r <= msg;
    if (cmd.op == OP_DIV_EUC) begin
      dq_r      <= {32'd0, ra_r};
      divisor_r <= rb_r;
      rem_r     <= '0;
    end else if (cmd.op == OP_DIV_MOD) begin
      dq_r      <= prod_r;
      divisor_r <= modulus_r;
      rem_r     <= '0;
    end else if (cnt_r != '0) begin
      dq_r  <= {dq_r[62:0], q_bit};
      rem_r <= rem_nxt;
    end
    case (cmd.op)
      OP_E_INIT: i_r <= WORD_WIDTH'(2);
      OP_GCD_LOAD: begin
        ra_r <= i_r;
        rb_r <= totient_r;
      end
      OP_GCD_STEP: begin
        ra_r <= rb_r;
        rb_r <= rem_r;
      end
      OP_NEXT_I: i_r <= i_r + 1'b1;
      OP_INV_LOAD: begin
        ra_r <= totient_r;
        rb_r <= e_r;
        t_r  <= '0;
        nt_r <= MUL_WIDTH'(1);
      end
      OP_INV_STEP: begin
        t_r  <= nt_r;
        nt_r <= t_r - $signed(prod_r[MUL_WIDTH-1:0]);
        ra_r <= rb_r;
        rb_r <= rem_r;
      end
      OP_X1_INIT: begin
        base_r <= WORD_WIDTH'(msg_r);
        exp_r  <= e_r;
      end
      OP_X2_INIT: begin
        cipher_r <= acc_r;
        base_r   <= acc_r;
        exp_r    <= d_r;
      end
      OP_ZERO_ACC: acc_r <= '0;
      OP_SET_ACC: acc_r <= rem_r;
      OP_SET_BASE: base_r <= rem_r;
      OP_SET_BASE_SH: begin
        base_r <= rem_r;
        exp_r  <= exp_r >> 1;
      end
      OP_FINISH: begin
        out_cipher_r <= cipher_r;
        out_rec_r    <= acc_r;
      end
      default: ;
    endcase
  end

  always_comb begin
    st.div_busy   = cnt_r != '0;
    st.phi_small  = totient_r <= WORD_WIDTH'(2);
    st.rb_zero    = rb_r == '0;
    st.ra_one     = ra_r == WORD_WIDTH'(1);
    st.i_ge_phi   = i_r >= totient_r;
    st.mod_zero   = modulus_r == '0;
    st.exp_zero   = exp_r == '0;
    st.exp_lsb    = exp_r[0];
    st.keys_ready = keys_ready_r;
  end

  assign cipher_out = out_cipher_r;
  assign rec_out    = out_rec_r;
  assign e_out      = e_r;
  assign d_out      = d_r;

endmodule

`default_nettype wire

FILE: rtl/trsa_ctrl.sv
// controller: sequences key derivation and the two modular exponentiations
// depends on trsa_pkg, drives trsa_datapath
`timescale 1ns / 1ps
`default_nettype none

module trsa_ctrl import trsa_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_ready,
  output logic         out_valid,
  input  wire logic    out_ready,
  input  wire status_t st,
  output cmd_t         cmd
);

  typedef enum logic [5:0] {
    S_IDLE, S_K_N, S_K_PHI, S_K_SETPHI, S_K_CHK, S_K_SMALL,
    S_E_INIT, S_E_CHK, S_E_LOOP, S_E_DIV, S_E_WAIT, S_E_STEP, S_E_TEST, S_E_SET,
    S_D_INIT, S_D_LOOP, S_D_DIV, S_D_WAIT, S_D_MUL, S_D_STEP, S_D_SET,
    S_X1_INIT, S_X_START, S_X_ONE_DIV, S_X_ONE_WAIT, S_X_ONE_SET,
    S_X_BASE, S_X_B_DIV, S_X_B_WAIT, S_X_B_SET, S_X_LOOP,
    S_X_MA, S_X_MA_DIV, S_X_MA_WAIT, S_X_MA_SET,
    S_X_SQ, S_X_SQ_DIV, S_X_SQ_WAIT, S_X_SQ_SET, S_X_END
  } state_t;

  state_t state_r, state_nxt;
  logic   pass_r, pass_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    pass_nxt      = pass_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd.op        = OP_NONE;
    cmd.msg_load  = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.msg_load = 1'b1;
          state_nxt    = st.keys_ready ? S_X1_INIT : S_K_N;
        end
      end
      S_K_N: begin
        cmd.op    = OP_MUL_N;
        state_nxt = S_K_PHI;
      end
      S_K_PHI: begin
        cmd.op    = OP_MUL_PHI;
        state_nxt = S_K_SETPHI;
      end
      S_K_SETPHI: begin
        cmd.op    = OP_SET_PHI;
        state_nxt = S_K_CHK;
      end
      S_K_CHK: state_nxt = st.phi_small ? S_K_SMALL : S_E_INIT;
      S_K_SMALL: begin
        cmd.op    = OP_SMALL_KEYS;
        state_nxt = S_X1_INIT;
      end
      // e search: candidate i against phi by euclid
      S_E_INIT: begin
        cmd.op    = OP_E_INIT;
        state_nxt = S_E_CHK;
      end
      S_E_CHK: begin
        cmd.op    = OP_GCD_LOAD;
        state_nxt = st.i_ge_phi ? S_E_SET : S_E_LOOP;
      end
      S_E_LOOP: state_nxt = st.rb_zero ? S_E_TEST : S_E_DIV;
      S_E_DIV: begin
        cmd.op    = OP_DIV_EUC;
        state_nxt = S_E_WAIT;
      end
      S_E_WAIT: if (!st.div_busy) state_nxt = S_E_STEP;
      S_E_STEP: begin
        cmd.op    = OP_GCD_STEP;
        state_nxt = S_E_LOOP;
      end
      S_E_TEST: begin
        if (st.ra_one) begin
          state_nxt = S_E_SET;
        end else begin
          cmd.op    = OP_NEXT_I;
          state_nxt = S_E_CHK;
        end
      end
      S_E_SET: begin
        cmd.op    = OP_SET_E;
        state_nxt = S_D_INIT;
      end
      // d by extended euclid
      S_D_INIT: begin
        cmd.op    = OP_INV_LOAD;
        state_nxt = S_D_LOOP;
      end
      S_D_LOOP: state_nxt = st.rb_zero ? S_D_SET : S_D_DIV;
      S_D_DIV: begin
        cmd.op    = OP_DIV_EUC;
        state_nxt = S_D_WAIT;
      end
      S_D_WAIT: if (!st.div_busy) state_nxt = S_D_MUL;
      S_D_MUL: begin
        cmd.op    = OP_INV_MUL;
        state_nxt = S_D_STEP;
      end
      S_D_STEP: begin
        cmd.op    = OP_INV_STEP;
        state_nxt = S_D_LOOP;
      end
      S_D_SET: begin
        cmd.op    = OP_SET_D;
        state_nxt = S_X1_INIT;
      end
      // square and multiply, run once with e and once with d
      S_X1_INIT: begin
        cmd.op    = OP_X1_INIT;
        pass_nxt  = 1'b0;
        state_nxt = S_X_START;
      end
      S_X_START: begin
        if (st.mod_zero) begin
          cmd.op    = OP_ZERO_ACC;
          state_nxt = S_X_END;
        end else begin
          cmd.op    = OP_LOAD_ONE;
          state_nxt = S_X_ONE_DIV;
        end
      end
      S_X_ONE_DIV: begin
        cmd.op    = OP_DIV_MOD;
        state_nxt = S_X_ONE_WAIT;
      end
      S_X_ONE_WAIT: if (!st.div_busy) state_nxt = S_X_ONE_SET;
      S_X_ONE_SET: begin
        cmd.op    = OP_SET_ACC;
        state_nxt = S_X_BASE;
      end
      S_X_BASE: begin
        cmd.op    = OP_LOAD_BASE;
        state_nxt = S_X_B_DIV;
      end
      S_X_B_DIV: begin
        cmd.op    = OP_DIV_MOD;
        state_nxt = S_X_B_WAIT;
      end
      S_X_B_WAIT: if (!st.div_busy) state_nxt = S_X_B_SET;
      S_X_B_SET: begin
        cmd.op    = OP_SET_BASE;
        state_nxt = S_X_LOOP;
      end
      S_X_LOOP: begin
        if (st.exp_zero) state_nxt = S_X_END;
        else state_nxt = st.exp_lsb ? S_X_MA : S_X_SQ;
      end
      S_X_MA: begin
        cmd.op    = OP_MUL_AB;
        state_nxt = S_X_MA_DIV;
      end
      S_X_MA_DIV: begin
        cmd.op    = OP_DIV_MOD;
        state_nxt = S_X_MA_WAIT;
      end
      S_X_MA_WAIT: if (!st.div_busy) state_nxt = S_X_MA_SET;
      S_X_MA_SET: begin
        cmd.op    = OP_SET_ACC;
        state_nxt = S_X_SQ;
      end
      S_X_SQ: begin
        cmd.op    = OP_MUL_BB;
        state_nxt = S_X_SQ_DIV;
      end
      S_X_SQ_DIV: begin
        cmd.op    = OP_DIV_MOD;
        state_nxt = S_X_SQ_WAIT;
      end
      S_X_SQ_WAIT: if (!st.div_busy) state_nxt = S_X_SQ_SET;
      S_X_SQ_SET: begin
        cmd.op    = OP_SET_BASE_SH;
        state_nxt = S_X_LOOP;
      end
      S_X_END: begin
        if (!pass_r) begin
          cmd.op    = OP_X2_INIT;
          pass_nxt  = 1'b1;
          state_nxt = S_X_START;
        end else if (!out_valid_r || out_ready) begin
          // output slot free or emptying this cycle
          cmd.op        = OP_FINISH;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pass_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pass_r      <= pass_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = state_r == S_IDLE;
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

FILE: rtl/toy_rsa_key_and_modexp.sv
// Textbook RSA on small primes: key derivation once, then m^e mod n and c^d mod n.
// Input channel in_*: tdata[7:0] is the message byte. Output channel out_*: tdata holds
// cipher value, recovered value, public and private exponent, 32 bits each.
// Config port cfg_*: index 0 writes prime p, index 1 prime q (reset 61 and 53).
// After reset the first request derives n, phi, e and d from the primes and keeps them;
// later prime writes do not change the keys, and reset restores the primes to 61 and 53.
// One request at a time. Every modular multiply goes through one shared 34x34 multiplier
// and a 64-step bit-serial divider. The time a byte takes grows with the bits and the
// set bits of e and d; the first request also runs the key search by euclid steps.
// A finished result sits in the output register while the next request is taken;
// if the receiver still stalls when the next result is ready, the block waits.
// Reset (rst_n, synchronous) clears the keys and empties the output.
// Depends on trsa_pkg, trsa_ctrl, trsa_datapath and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module toy_rsa_key_and_modexp import trsa_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic                  cfg_addr,
  input  wire logic [CFG_WIDTH-1:0]  cfg_wdata,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [7:0]            in_tdata,   // message_byte
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // cipher_value, recovered_value, public_exponent, private_exponent
  output logic [4*WORD_WIDTH-1:0]    out_tdata
);

  cmd_t    cmd;
  status_t st;
  logic [WORD_WIDTH-1:0] cipher, rec, e_val, d_val;

  trsa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .st        (st),
    .cmd       (cmd)
  );

  trsa_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .msg        (in_tdata),
    .cmd        (cmd),
    .st         (st),
    .cipher_out (cipher),
    .rec_out    (rec),
    .e_out      (e_val),
    .d_out      (d_val)
  );

  assign out_tdata = {d_val, e_val, rec, cipher};

  `ASSERT_CLK(a_accept_idle_div, (in_tvalid && in_tready) |-> !st.div_busy, "request taken during division")
  `ASSERT_NEVER(a_div_overlap, (cmd.op == OP_DIV_EUC || cmd.op == OP_DIV_MOD) && st.div_busy, "division restarted while busy")
  `ASSERT_CLK(a_keys_kept, st.keys_ready |=> st.keys_ready, "keys lost without reset")
  `ASSERT_CLK(a_out_keys, out_tvalid |-> st.keys_ready, "result before keys derived")

endmodule

`default_nettype wire

FILE: tb/sv/tb_toy_rsa_key_and_modexp.sv
// testbench for toy_rsa_key_and_modexp: sends message bytes, predicts the rsa result
// and checks every output request field by field. depends on trsa_pkg and the rtl
`timescale 1ns / 1ps
`default_nettype none

module tb_toy_rsa_key_and_modexp;
  import trsa_pkg::*;

  typedef struct packed {
    logic [31:0] dexp;
    logic [31:0] eexp;
    logic [31:0] recovered;
    logic [31:0] cipher;
  } rsa_result_t;

  localparam int STALL_LIMIT = 200000;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic                 cfg_addr;
  logic [CFG_WIDTH-1:0] cfg_wdata;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [7:0]           in_tdata;   // message_byte
  logic                 out_tvalid;
  logic                 out_tready;
  // cipher_value, recovered_value, public_exponent, private_exponent
  logic [127:0]         out_tdata;

  toy_rsa_key_and_modexp dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  // shadow of the prime registers and derived keys
  logic [PRIME_WIDTH-1:0] shadow_p, shadow_q;
  logic [31:0] key_n, key_phi, key_e, key_d;
  bit          key_valid;

  rsa_result_t expected_results[$];
  int  mismatches;
  bit  tx_idle_en, rx_idle_en;
  int  rx_hold;
  int  rx_burst;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [31:0] gcd32(logic [31:0] a, logic [31:0] b);
    logic [31:0] t;
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    return a;
  endfunction

  function automatic logic [31:0] modinv(logic [31:0] a, logic [31:0] m);
    longint t, nt, r, nr, k, tmp;
    t = 0; nt = 1; r = m; nr = a % m;
    while (nr != 0) begin
      k = r / nr;
      tmp = t - k * nt; t = nt; nt = tmp;
      tmp = r - k * nr; r = nr; nr = tmp;
    end
    if (t < 0) t += m;
    return t[31:0];
  endfunction

  function automatic logic [31:0] powmod(logic [31:0] base, logic [31:0] ex, logic [31:0] m);
    logic [63:0] acc, b;
    if (m == 0) return 32'd0;
    acc = 64'd1 % m;
    b = base % m;
    while (ex != 0) begin
      if (ex[0]) acc = (acc * b) % m;
      b = (b * b) % m;
      ex = ex >> 1;
    end
    return acc[31:0];
  endfunction

  task automatic derive_rsa_keys();
    logic [31:0] pm, qm, i;
    logic [63:0] prod;
    pm = (shadow_p != 0) ? shadow_p - 1 : 0;
    qm = (shadow_q != 0) ? shadow_q - 1 : 0;
    prod = 64'(shadow_p) * 64'(shadow_q);
    key_n = prod[31:0];
    prod = 64'(pm) * 64'(qm);
    key_phi = prod[31:0];
    if (key_phi <= 2) begin
      key_e = 2;
      key_d = 2;
    end else begin
      for (i = 2; i < key_phi; i++)
        if (gcd32(i, key_phi) == 1) break;
      key_e = i;
      key_d = modinv(i, key_phi);
      if (key_d < 2) key_d = key_phi;
    end
    key_valid = 1'b1;
  endtask

  function automatic rsa_result_t predict_rsa(logic [7:0] msg);
    rsa_result_t r;
    r.cipher    = powmod(32'(msg), key_e, key_n);
    r.recovered = powmod(r.cipher, key_d, key_n);
    r.eexp      = key_e;
    r.dexp      = key_d;
    return r;
  endfunction

  task automatic write_prime(logic idx, logic [CFG_WIDTH-1:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_PRIME_P) shadow_p = val[PRIME_WIDTH-1:0];
    else shadow_q = val[PRIME_WIDTH-1:0];
    @(posedge clk);
  endtask

  // leaves tvalid high unless a random idle gap is drawn, so back-to-back requests need no second assignment
  task automatic send_byte(logic [7:0] msg);
    in_tvalid <= 1'b1;
    in_tdata <= msg;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (!key_valid) derive_rsa_keys();
    expected_results.push_back(predict_rsa(msg));
    if (tx_idle_en && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  task automatic pause_sender();
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (expected_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // receiver ready: random stall bursts plus an optional long hold
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (rx_hold > 0) begin
      out_tready <= 1'b0;
      rx_hold <= rx_hold - 1;
    end else if (rx_burst > 0) begin
      out_tready <= 1'b0;
      rx_burst <= rx_burst - 1;
    end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
      out_tready <= 1'b0;
      rx_burst <= $urandom_range(0, 13);
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    rsa_result_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        want = expected_results.pop_front();
        if (got != want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp c=%0d r=%0d e=%0d d=%0d got c=%0d r=%0d e=%0d d=%0d",
                     want.cipher, want.recovered, want.eexp, want.dexp,
                     got.cipher, got.recovered, got.eexp, got.dexp);
        end
      end
    end
  end

  // cycles with no request moving on either side
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
      else quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("toy_rsa_key_and_modexp test failed");
        $finish;
      end
    end
  end

  task automatic test_prime_setup();
    write_prime(REG_PRIME_P, 16'd251);
    write_prime(REG_PRIME_Q, 16'd241);
  endtask

  task automatic test_directed_bytes();
    logic [7:0] msgs[12];
    msgs = '{8'd0, 8'd1, 8'd2, 8'd255, 8'd128, 8'd127, 8'h55, 8'hAA, 8'h0F, 8'hF0, 8'd3, 8'd254};
    foreach (msgs[k]) send_byte(msgs[k]);
    pause_sender();
    wait_drained();
  endtask

  // keys are latched, so later prime writes must not change results
  task automatic test_prime_write_after_keys();
    write_prime(REG_PRIME_P, 16'hFFFF);
    write_prime(REG_PRIME_Q, 16'd0);
    send_byte(8'd200);
    send_byte(8'd7);
    pause_sender();
    wait_drained();
    write_prime(REG_PRIME_P, 16'd2);
    write_prime(REG_PRIME_Q, 16'hFFFF);
    send_byte(8'd99);
    pause_sender();
    wait_drained();
  endtask

  task automatic test_random_bytes(int count);
    repeat (count) send_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic test_output_backpressure();
    rx_hold = 20000;
    repeat (4) send_byte(8'($urandom_range(0, 255)));
    pause_sender();
    wait_drained();
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = REG_PRIME_P;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    shadow_p = PRIME_P_RESET;
    shadow_q = PRIME_Q_RESET;
    key_valid = 1'b0;
    mismatches = 0;
    rx_hold = 0;
    rx_burst = 0;
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_prime_setup();
    test_directed_bytes();
    test_prime_write_after_keys();
    test_random_bytes(60);
    pause_sender();
    wait_drained();
    test_output_backpressure();
    test_random_bytes(50);
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    test_random_bytes(12);
    pause_sender();
    wait_drained();
    repeat (200) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0)
      $display("toy_rsa_key_and_modexp test passed");
    else
      $display("toy_rsa_key_and_modexp test failed");
    $finish;
  end

endmodule

`default_nettype wire
